>>> rtl/core/flr_pkg.sv
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants
// Character codes, the classified item that crosses the queue and the
// result record of the framed line receiver.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int Q_DEPTH          = 2;
  localparam int QA_W             = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W             = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One accepted item after decode.
  typedef struct packed {
    logic       abort;
    logic       is_eol;
    logic       is_star;
    logic       is_dollar;
    logic       is_hex;
    logic [3:0] nib;
    logic [7:0] ch;
  } cls_t;

  // One result item.
  typedef struct packed {
    logic       stored_valid;
    logic [5:0] stored_index;
    logic [7:0] stored_char;
    logic       line_end;
    logic       frame_started;
    logic       star_seen;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [1:0] received_digits;
    logic [6:0] frame_length;
  } res_t;

endpackage

>>> rtl/core/flr_rx_if.sv
// ----------------------------------------------------------------------------
// flr_rx_if: receive channel
// Valid/ready channel that carries one command or received byte per item.
// ----------------------------------------------------------------------------
interface flr_rx_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> rtl/core/flr_res_if.sv
// ----------------------------------------------------------------------------
// flr_res_if: result channel
// Valid/ready channel that carries one result item per received item.
// ----------------------------------------------------------------------------
interface flr_res_if;
  logic       valid;
  logic       ready;
  logic       stored_valid;
  logic [5:0] stored_index;
  logic [7:0] stored_char;
  logic       line_end;
  logic       frame_started;
  logic       star_seen;
  logic       checksum_ok;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;
  logic [1:0] received_digits;
  logic [6:0] frame_length;

  modport source (
    output valid, output stored_valid, output stored_index, output stored_char,
    output line_end, output frame_started, output star_seen, output checksum_ok,
    output computed_checksum, output received_checksum, output received_digits,
    output frame_length, input ready
  );
  modport sink (
    input valid, input stored_valid, input stored_index, input stored_char,
    input line_end, input frame_started, input star_seen, input checksum_ok,
    input computed_checksum, input received_checksum, input received_digits,
    input frame_length, output ready
  );
endinterface

>>> rtl/core/flr_front.sv
// ----------------------------------------------------------------------------
// flr_front: receive side decode
// Accepts items from the receive channel and classifies each byte
// (line end, star, dollar, hex digit value) before it enters the queue.
// ----------------------------------------------------------------------------
module flr_front (
  input  logic          rst,
  flr_rx_if.sink        rx,
  input  logic          q_ready,
  output logic          q_push,
  output flr_pkg::cls_t q_item
);

  logic [7:0] c;
  logic [7:0] diff;

  assign c        = rx.rx_byte;
  // no item is taken while reset is applied
  assign rx.ready = q_ready && !rst;
  assign q_push   = rx.valid && rx.ready;

  always_comb begin
    diff             = 8'h00;
    q_item.abort     = rx.cmd;
    q_item.is_eol    = (c == flr_pkg::CH_LF) || (c == flr_pkg::CH_CR);
    q_item.is_star   = (c == flr_pkg::CH_STAR);
    q_item.is_dollar = (c == flr_pkg::CH_DOLLAR);
    q_item.ch        = c;
    q_item.is_hex    = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
    end else begin
      q_item.is_hex = 1'b0;
    end
    q_item.nib = diff[3:0];
  end

endmodule

>>> rtl/core/flr_queue.sv
// ----------------------------------------------------------------------------
// flr_queue: decoupling queue
// Short FIFO of classified items between the decode and the line logic.
// ----------------------------------------------------------------------------
module flr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  flr_pkg::cls_t push_item,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output flr_pkg::cls_t head_item
);

  flr_pkg::cls_t             slots [flr_pkg::Q_DEPTH];
  logic [flr_pkg::QA_W-1:0]  wr_ptr;
  logic [flr_pkg::QA_W-1:0]  rd_ptr;
  logic [flr_pkg::QC_W-1:0]  count;

  localparam logic [flr_pkg::QA_W-1:0] LAST = flr_pkg::QA_W'(flr_pkg::Q_DEPTH - 1);
  localparam logic [flr_pkg::QC_W-1:0] FULL = flr_pkg::QC_W'(flr_pkg::Q_DEPTH);

  assign not_full   = (count != FULL);
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/core/flr_back.sv
// ----------------------------------------------------------------------------
// flr_back: line state and result register
// Carries out each classified item against the line state (framing, store
// index, running XOR, checksum digits) and holds the result for the sink.
// ----------------------------------------------------------------------------
module flr_back #(
  parameter int BUFFER_DEPTH = flr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  flr_pkg::cls_t q_item,
  output logic          q_pop,
  flr_res_if.source     res
);

  localparam int WI_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [WI_W-1:0] DEPTH_W = WI_W'(BUFFER_DEPTH);

  logic            line_busy, line_busy_next;
  logic            begun, begun_next;
  logic            after_star, after_star_next;
  logic [WI_W-1:0] write_index, write_index_next;
  logic [1:0]      digit_count, digit_count_next;
  logic [7:0]      digit_value, digit_value_next;
  logic            digits_are_hex, digits_are_hex_next;
  logic [7:0]      running_xor, running_xor_next;

  logic            res_valid;
  flr_pkg::res_t   rr, rr_next;

  // line state as seen by this item (an idle line starts out cleared)
  logic            b0, as0, hex0, as1, st1, st2;
  logic [WI_W-1:0] wi0, wi1, wi2;
  logic [1:0]      dc0;
  logic [7:0]      dv0, x0, x1, x2;
  logic [8:0]      wi_ext;

  assign q_pop = q_valid && (!res_valid || res.ready);

  always_comb begin
    b0   = line_busy && begun;
    as0  = line_busy && after_star;
    wi0  = line_busy ? write_index : '0;
    dc0  = line_busy ? digit_count : 2'd0;
    dv0  = line_busy ? digit_value : 8'h00;
    hex0 = line_busy ? digits_are_hex : 1'b1;
    x0   = line_busy ? running_xor : 8'h00;

    as1 = as0 || q_item.is_star;
    st1 = b0 && (wi0 < DEPTH_W);
    wi1 = wi0 + WI_W'(st1);
    x1  = x0 ^ ((st1 && wi0 != '0 && !as1) ? q_item.ch : 8'h00);
    // a dollar stores itself once more
    st2 = q_item.is_dollar && (wi1 < DEPTH_W);
    wi2 = wi1 + WI_W'(st2);
    x2  = x1 ^ ((st2 && wi1 != '0 && !as1) ? q_item.ch : 8'h00);
    wi_ext = 9'(wi0);

    line_busy_next      = line_busy;
    begun_next          = begun;
    after_star_next     = after_star;
    write_index_next    = write_index;
    digit_count_next    = digit_count;
    digit_value_next    = digit_value;
    digits_are_hex_next = digits_are_hex;
    running_xor_next    = running_xor;
    rr_next             = '0;

    if (q_item.abort) begin
      line_busy_next  = 1'b0;
      begun_next      = 1'b0;
      after_star_next = 1'b0;
    end else if (q_item.is_eol) begin
      line_busy_next            = 1'b0;
      begun_next                = 1'b0;
      after_star_next           = 1'b0;
      rr_next.line_end          = 1'b1;
      rr_next.frame_started     = b0;
      rr_next.star_seen         = as0;
      rr_next.checksum_ok       = (dc0 == 2'd2) && hex0 && (dv0 == x0);
      rr_next.computed_checksum = x0;
      rr_next.received_checksum = dv0;
      rr_next.received_digits   = dc0;
      rr_next.frame_length      = wi_ext[6:0];
    end else begin
      line_busy_next      = 1'b1;
      begun_next          = b0 || q_item.is_dollar;
      after_star_next     = as1;
      write_index_next    = wi2;
      running_xor_next    = x2;
      digit_count_next    = dc0;
      digit_value_next    = dv0;
      digits_are_hex_next = hex0;
      // capture a checksum digit; a non-hex one counts as zero
      if (b0 && as0 && dc0 != 2'd2) begin
        digit_count_next    = dc0 + 2'd1;
        digit_value_next    = {dv0[3:0], q_item.is_hex ? q_item.nib : 4'h0};
        digits_are_hex_next = hex0 && q_item.is_hex;
      end
      if (st1 || st2) begin
        rr_next.stored_valid = 1'b1;
        rr_next.stored_index = wi_ext[5:0];
        rr_next.stored_char  = q_item.ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_busy      <= 1'b0;
      begun          <= 1'b0;
      after_star     <= 1'b0;
      write_index    <= '0;
      digit_count    <= 2'd0;
      digit_value    <= 8'h00;
      digits_are_hex <= 1'b1;
      running_xor    <= 8'h00;
      res_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        line_busy      <= line_busy_next;
        begun          <= begun_next;
        after_star     <= after_star_next;
        write_index    <= write_index_next;
        digit_count    <= digit_count_next;
        digit_value    <= digit_value_next;
        digits_are_hex <= digits_are_hex_next;
        running_xor    <= running_xor_next;
        res_valid      <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rr <= rr_next;
    end
  end

  assign res.valid             = res_valid;
  assign res.stored_valid      = rr.stored_valid;
  assign res.stored_index      = rr.stored_index;
  assign res.stored_char       = rr.stored_char;
  assign res.line_end          = rr.line_end;
  assign res.frame_started     = rr.frame_started;
  assign res.star_seen         = rr.star_seen;
  assign res.checksum_ok       = rr.checksum_ok;
  assign res.computed_checksum = rr.computed_checksum;
  assign res.received_checksum = rr.received_checksum;
  assign res.received_digits   = rr.received_digits;
  assign res.frame_length      = rr.frame_length;

endmodule

>>> rtl/core/framed_line_receiver_xor_check.sv
// ----------------------------------------------------------------------------
// framed_line_receiver_xor_check: framed line receiver with XOR check
// Frames $...*HH lines ended by CR or LF and checks the XOR checksum.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one item per handshake: cmd 0 with a received byte in
//   rx_byte, or cmd 1 to abort the current line. res returns exactly one
//   result item for every rx item, in order.
//   A stored character is reported with its buffer index; a line end
//   reports framing flags, length, computed and received checksum and the
//   match flag.
//   Throughput is one item per cycle while res is not stalled: decode
//   feeds a two-entry queue and the line state updates as an item leaves
//   the queue. An accepted item is written into the queue and its result
//   is registered into the result register on res as it leaves the queue.
//   When res stalls, the result register holds, the queue fills and
//   rx.ready drops once both queue entries are taken.
//   Synchronous reset empties the queue and result register and puts the
//   line idle; rx.ready is low while rst is high.
// ----------------------------------------------------------------------------
module framed_line_receiver_xor_check #(
  parameter int BUFFER_DEPTH = flr_pkg::BUFFER_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  flr_rx_if.sink    rx,
  flr_res_if.source res
);

  logic          q_ready;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  flr_pkg::cls_t push_item;
  flr_pkg::cls_t head_item;

  flr_front u_front (
    .rst    (rst),
    .rx     (rx),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_item (push_item)
  );

  flr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .not_full  (q_ready),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (head_item)
  );

  flr_back #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_item (head_item),
    .q_pop  (q_pop),
    .res    (res)
  );

  // an accepted item is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_valid)
    else $error("accepted item missing from queue");

  a_store_not_eol: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.stored_valid) |-> !res.line_end)
    else $error("store and line end in one result");

  a_ok_needs_digits: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.checksum_ok) |-> (res.line_end && res.received_digits == 2'd2))
    else $error("checksum match without two digits at line end");

endmodule
